FILE: hw/rtl/sts_pkg.sv
package sts_pkg;

	localparam int unsigned DEFAULT_TABLE_DEPTH = 65536;
	localparam int unsigned KEY_W   = 32;
	localparam int unsigned INDEX_W = 16;
	localparam int unsigned COUNT_W = 17;
	localparam int unsigned TALLY_W = 18;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 17;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SEARCH_MODE = 1'b0,
		REG_ENTRY_COUNT = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_INTERP = 2'd0,
		MODE_BINARY = 2'd1,
		MODE_SEQ    = 2'd2
	} search_mode_t;

	typedef enum logic {
		FUNC_LOAD   = 1'b0,
		FUNC_SEARCH = 1'b1
	} func_t;

	localparam logic [1:0] MISS_COST = 2'd2;
	localparam logic [1:0] HIT_COST  = 2'd1;

	function automatic logic [TALLY_W-1:0] tally_add(input logic [TALLY_W-1:0] t,
			input logic [1:0] n);
		logic [TALLY_W:0] s;
		s = {1'b0, t} + (TALLY_W+1)'(n);
		return s[TALLY_W] ? '1 : s[TALLY_W-1:0];
	endfunction

endpackage

FILE: hw/rtl/sts_table.sv
module sts_table import sts_pkg::*; #(
	parameter int unsigned DEPTH = DEFAULT_TABLE_DEPTH,
	parameter int unsigned AW = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [KEY_W-1:0]  wdata,
	input  logic [AW-1:0]     raddr,
	output logic [KEY_W-1:0]  rdata
);

	logic [KEY_W-1:0] mem [DEPTH];
	logic [KEY_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/sts_divider.sv
module sts_divider import sts_pkg::*; #(
	parameter int unsigned QW = 17
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [KEY_W+QW-1:0] dividend,
	input  logic [KEY_W-1:0]    divisor,
	output logic                idle,
	output logic [QW-1:0]       quotient
);

	localparam int unsigned CNT_W = $clog2(QW + 1);

	logic [KEY_W-1:0] rem_q;
	logic [KEY_W-1:0] div_q;
	logic [QW-1:0]    quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic [KEY_W:0]   trial;
	logic [KEY_W:0]   diff;

	assign trial = {rem_q, quo_q[QW-1]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(QW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[KEY_W+QW-1:QW];
			quo_q <= dividend[QW-1:0];
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!diff[KEY_W]) begin
				rem_q <= diff[KEY_W-1:0];
				quo_q <= {quo_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= trial[KEY_W-1:0];
				quo_q <= {quo_q[QW-2:0], 1'b0};
			end
		end
	end

	assign idle     = (cnt_q == '0);
	assign quotient = quo_q;

endmodule

FILE: hw/rtl/sts_ctrl.sv
module sts_ctrl import sts_pkg::*; #(
	parameter int unsigned DEPTH = DEFAULT_TABLE_DEPTH,
	parameter int unsigned AW = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  func,
	input  logic [INDEX_W-1:0]    entry_index,
	input  logic [KEY_W-1:0]      item_value,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  done,
	output logic                  found,
	output logic [INDEX_W-1:0]    found_index,
	output logic [TALLY_W-1:0]    compare_count,
	output logic                  tbl_we,
	output logic [AW-1:0]         tbl_waddr,
	output logic [KEY_W-1:0]      tbl_wdata,
	output logic [AW-1:0]         tbl_raddr,
	input  logic [KEY_W-1:0]      tbl_rdata,
	output logic                  div_start,
	output logic [KEY_W+AW:0]     div_dividend,
	output logic [KEY_W-1:0]      div_divisor,
	input  logic                  div_idle,
	input  logic [AW:0]           div_quotient
);

	localparam int unsigned QW = AW + 1;
	localparam int unsigned CW = AW + 1;
	localparam int unsigned IW = AW + 2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_I_CHK,
		ST_I_ALO,
		ST_I_AHI,
		ST_I_MUL,
		ST_I_DIV,
		ST_B_CHK,
		ST_P_CMP,
		ST_S_CHK,
		ST_S_CMP
	} state_t;

	state_t state_q;

	logic [1:0]           mode_q;
	logic [CW-1:0]        count_q;
	logic signed [IW-1:0] lo_q;
	logic signed [IW-1:0] hi_q;
	logic signed [IW-1:0] pos_q;
	logic signed [KEY_W-1:0] key_q;
	logic signed [KEY_W-1:0] alo_q;
	logic [KEY_W-1:0]     num_q;
	logic [KEY_W-1:0]     den_q;
	logic [QW-1:0]        span_q;
	logic [TALLY_W-1:0]   tally_q;
	logic                 done_q;
	logic                 found_q;
	logic [INDEX_W-1:0]   index_q;
	logic [TALLY_W-1:0]   ccount_q;

	logic                 accept;
	logic signed [KEY_W-1:0] rd_val;
	logic signed [IW-1:0] count_s;
	logic signed [IW-1:0] mid;
	logic signed [IW-1:0] ipos;
	logic [CW-1:0]        cfg_count;
	logic signed [KEY_W:0] key_minus_alo;
	logic signed [KEY_W:0] ahi_minus_alo;
	logic signed [IW-1:0] hi_minus_lo;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign rd_val  = $signed(tbl_rdata);
	assign count_s = $signed({1'b0, count_q});
	assign hi_minus_lo = hi_q - lo_q;
	assign mid     = lo_q + (hi_minus_lo >>> 1);
	assign ipos    = lo_q + $signed({1'b0, div_quotient});
	assign key_minus_alo = {key_q[KEY_W-1], key_q} - {alo_q[KEY_W-1], alo_q};
	assign ahi_minus_alo = {rd_val[KEY_W-1], rd_val} - {alo_q[KEY_W-1], alo_q};
	assign cfg_count = ({15'd0, cfg_data} > 32'(DEPTH)) ? CW'(DEPTH) : CW'(cfg_data);

	assign tbl_we    = accept && (func == FUNC_LOAD) && (32'(entry_index) < 32'(DEPTH));
	assign tbl_waddr = AW'(entry_index);
	assign tbl_wdata = item_value;

	assign div_start    = (state_q == ST_I_MUL);
	assign div_dividend = num_q * span_q;
	assign div_divisor  = den_q;

	always_comb begin
		unique case (state_q)
			ST_I_ALO: tbl_raddr = hi_q[AW-1:0];
			ST_I_DIV: tbl_raddr = ipos[AW-1:0];
			ST_B_CHK: tbl_raddr = mid[AW-1:0];
			default:  tbl_raddr = lo_q[AW-1:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_INTERP;
			count_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SEARCH_MODE: mode_q  <= cfg_data[1:0];
				REG_ENTRY_COUNT: count_q <= cfg_count;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			lo_q     <= '0;
			hi_q     <= '0;
			tally_q  <= '0;
			done_q   <= 1'b0;
			found_q  <= 1'b0;
			index_q  <= '0;
			ccount_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && func == FUNC_SEARCH) begin
						key_q   <= $signed(item_value);
						lo_q    <= '0;
						hi_q    <= count_s - 1'b1;
						tally_q <= '0;
						if (count_q == '0) begin
							done_q   <= 1'b1;
							found_q  <= 1'b0;
							index_q  <= '0;
							ccount_q <= '0;
						end else begin
							case (mode_q)
								MODE_INTERP: state_q <= ST_I_CHK;
								MODE_BINARY: state_q <= ST_B_CHK;
								MODE_SEQ:    state_q <= ST_S_CHK;
								default: begin
									done_q   <= 1'b1;
									found_q  <= 1'b0;
									index_q  <= '0;
									ccount_q <= '0;
								end
							endcase
						end
					end
				end
				ST_I_CHK: begin
					if (hi_q < lo_q) begin
						done_q   <= 1'b1;
						found_q  <= 1'b0;
						index_q  <= '0;
						ccount_q <= tally_q;
						state_q  <= ST_IDLE;
					end else begin
						state_q <= ST_I_ALO;
					end
				end
				ST_I_ALO: begin
					alo_q   <= rd_val;
					state_q <= ST_I_AHI;
				end
				ST_I_AHI: begin
					if (key_q < alo_q || key_q > rd_val) begin
						done_q   <= 1'b1;
						found_q  <= 1'b0;
						index_q  <= '0;
						ccount_q <= tally_q;
						state_q  <= ST_IDLE;
					end else if (hi_q == lo_q || rd_val == alo_q) begin
						pos_q   <= lo_q;
						state_q <= ST_P_CMP;
					end else begin
						num_q   <= key_minus_alo[KEY_W-1:0];
						den_q   <= ahi_minus_alo[KEY_W-1:0];
						span_q  <= hi_minus_lo[QW-1:0];
						state_q <= ST_I_MUL;
					end
				end
				ST_I_MUL: begin
					state_q <= ST_I_DIV;
				end
				ST_I_DIV: begin
					if (div_idle) begin
						pos_q   <= ipos;
						state_q <= ST_P_CMP;
					end
				end
				ST_B_CHK: begin
					if (hi_q < lo_q) begin
						done_q   <= 1'b1;
						found_q  <= 1'b0;
						index_q  <= '0;
						ccount_q <= tally_q;
						state_q  <= ST_IDLE;
					end else begin
						pos_q   <= mid;
						state_q <= ST_P_CMP;
					end
				end
				ST_P_CMP: begin
					if (rd_val == key_q) begin
						done_q   <= 1'b1;
						found_q  <= 1'b1;
						index_q  <= INDEX_W'(pos_q);
						ccount_q <= tally_add(tally_q, HIT_COST);
						state_q  <= ST_IDLE;
					end else begin
						tally_q <= tally_add(tally_q, MISS_COST);
						if (rd_val < key_q) begin
							lo_q <= pos_q + 1'b1;
						end else begin
							hi_q <= pos_q - 1'b1;
						end
						state_q <= (mode_q == MODE_BINARY) ? ST_B_CHK : ST_I_CHK;
					end
				end
				ST_S_CHK: begin
					if (lo_q >= count_s) begin
						done_q   <= 1'b1;
						found_q  <= 1'b0;
						index_q  <= '0;
						ccount_q <= tally_q;
						state_q  <= ST_IDLE;
					end else begin
						state_q <= ST_S_CMP;
					end
				end
				ST_S_CMP: begin
					tally_q <= tally_add(tally_q, HIT_COST);
					if (rd_val == key_q) begin
						done_q   <= 1'b1;
						found_q  <= 1'b1;
						index_q  <= INDEX_W'(lo_q);
						ccount_q <= tally_add(tally_q, HIT_COST);
						state_q  <= ST_IDLE;
					end else begin
						lo_q    <= lo_q + 1'b1;
						state_q <= ST_S_CHK;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done          = done_q;
	assign found         = found_q;
	assign found_index   = index_q;
	assign compare_count = ccount_q;

endmodule

FILE: hw/rtl/sorted_table_search_engine_top.sv
// Sorted table search engine. A load (func 0) writes item_value into the table
// at entry_index, if below TABLE_DEPTH, in the cycle it is accepted and returns
// no result; busy stays low. A search (func 1) with a nonzero entry count and
// a valid mode raises busy until done pulses for one cycle with found,
// found_index and compare_count; the receiver cannot stall, so the result must
// be captured in that cycle. All table reads go through one registered
// single-port-read memory. A sequential search passes a check and a compare
// state per element, a binary search likewise per probe, and an interpolation
// search adds end-key reads, a multiply and a bit-serial divide per probe.
// Write configuration only while busy is low and no done is pending.
module sorted_table_search_engine_top import sts_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  func,
	input  logic [INDEX_W-1:0]    entry_index,
	input  logic [KEY_W-1:0]      item_value,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  done,
	output logic                  found,
	output logic [INDEX_W-1:0]    found_index,
	output logic [TALLY_W-1:0]    compare_count
);

	localparam int unsigned AW = $clog2(TABLE_DEPTH);

	logic              tbl_we;
	logic [AW-1:0]     tbl_waddr;
	logic [KEY_W-1:0]  tbl_wdata;
	logic [AW-1:0]     tbl_raddr;
	logic [KEY_W-1:0]  tbl_rdata;
	logic              div_start;
	logic [KEY_W+AW:0] div_dividend;
	logic [KEY_W-1:0]  div_divisor;
	logic              div_idle;
	logic [AW:0]       div_quotient;

	sts_ctrl #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_ctrl (
		.clk, .arst_n, .start, .busy, .func, .entry_index, .item_value,
		.cfg_we, .cfg_index, .cfg_data, .done, .found, .found_index, .compare_count,
		.tbl_we, .tbl_waddr, .tbl_wdata, .tbl_raddr, .tbl_rdata,
		.div_start, .div_dividend, .div_divisor, .div_idle, .div_quotient
	);

	sts_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
		.clk, .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
		.raddr(tbl_raddr), .rdata(tbl_rdata)
	);

	sts_divider #(.QW(AW + 1)) u_div (
		.clk, .arst_n, .start(div_start), .dividend(div_dividend),
		.divisor(div_divisor), .idle(div_idle), .quotient(div_quotient)
	);

endmodule
